/* src/sha1h_pkg.sv */
// shared types and constants of the sha-1 byte stream hasher
`timescale 1ns / 1ps
`default_nettype none
package sha1h_pkg;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } cmd_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        status;
  } res_word_t;

  localparam logic [1:0] MODE_ABSORB  = 2'd0;
  localparam logic [1:0] MODE_FINISH  = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  typedef enum logic [2:0] {
    OP_ABSORB,
    OP_FIN_PAD,
    OP_FIN_REPEAT,
    OP_FIN_ERR,
    OP_RESTART
  } job_op_t;

  // arg holds the byte for an absorb and the bit length for a padded finish
  typedef struct packed {
    job_op_t     op;
    logic [63:0] arg;
  } job_t;

  localparam logic [31:0] SHA1_IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [5:0] LEN_OFFSET  = 6'd56;
  localparam logic [6:0] LAST_ROUND  = 7'd79;
  localparam logic [2:0] LAST_DIGEST = 3'd4;

endpackage
`default_nettype wire

/* src/sha1h_front.sv */
// front end: tracks length and stream flags and turns words into jobs
`timescale 1ns / 1ps
`default_nettype none
module sha1h_front
  import sha1h_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_stall,
  input  wire cmd_word_t cmd_word,
  input  wire logic      q_full,
  output logic           push,
  output job_t           push_job
);

  logic [63:0] bit_length;
  logic [63:0] bit_length_next;
  logic        finished;
  logic        corrupt;
  logic        accept;

  assign cmd_stall       = q_full;
  assign accept          = cmd_valid && !q_full;
  assign bit_length_next = bit_length + 64'd8;

  always_comb begin
    push         = 1'b0;
    push_job.op  = OP_ABSORB;
    push_job.arg = '0;
    case (cmd_word.mode)
      MODE_ABSORB: begin
        if (!finished && !corrupt) begin
          push         = accept;
          push_job.op  = OP_ABSORB;
          push_job.arg = {56'd0, cmd_word.data_byte};
        end
      end
      MODE_FINISH: begin
        push = accept;
        if (corrupt) begin
          push_job.op = OP_FIN_ERR;
        end else if (!finished) begin
          push_job.op  = OP_FIN_PAD;
          push_job.arg = bit_length;
        end else begin
          push_job.op = OP_FIN_REPEAT;
        end
      end
      MODE_RESTART: begin
        push        = accept;
        push_job.op = OP_RESTART;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_length <= '0;
      finished   <= 1'b0;
      corrupt    <= 1'b0;
    end else if (accept) begin
      case (cmd_word.mode)
        MODE_ABSORB: begin
          if (finished || corrupt) begin
            corrupt <= 1'b1;
          end else begin
            bit_length <= bit_length_next;
            // length wrapped around
            if (bit_length_next == 64'd0) corrupt <= 1'b1;
          end
        end
        MODE_FINISH: begin
          if (!corrupt) finished <= 1'b1;
        end
        MODE_RESTART: begin
          bit_length <= '0;
          finished   <= 1'b0;
          corrupt    <= 1'b0;
        end
        default: begin
          finished <= finished;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/sha1h_queue.sv */
// small job queue between front end and hash core
`timescale 1ns / 1ps
`default_nettype none
module sha1h_queue
  import sha1h_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        slots[wr_ptr] <= push_job;
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && head_valid) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && head_valid})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/sha1h_core.sv */
// hash core: block assembly, padding, 80-round compression and digest and error word output
`timescale 1ns / 1ps
`default_nettype none
module sha1h_core
  import sha1h_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire job_t q_job,
  output logic      q_pop,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_word_t res_word
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PS_NONE,
    PS_MARK,
    PS_ZERO,
    PS_LEN,
    PS_DONE
  } pad_stage_t;

  state_t      state;
  pad_stage_t  pad_stage;
  logic [5:0]  fill;
  logic [23:0] wacc;
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [6:0]  rnd;
  logic [31:0] chain [5];
  logic [63:0] len_sr;
  logic [2:0]  len_cnt;
  logic [2:0]  emit_idx;

  logic        slot_free;
  logic        res_load;
  logic        absorb_en;
  logic [7:0]  absorb_byte;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_next;
  logic [31:0] w_mix;
  logic [31:0] w_sched;

  assign slot_free = !res_valid || !res_stall;

  // a result word is loaded this cycle
  assign res_load = (state == ST_EMIT && slot_free) ||
                    (state == ST_IDLE && q_pop && q_job.op == OP_FIN_ERR);

  always_comb begin
    q_pop       = 1'b0;
    absorb_en   = 1'b0;
    absorb_byte = 8'd0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_job.op)
            OP_ABSORB: begin
              q_pop       = 1'b1;
              absorb_en   = 1'b1;
              absorb_byte = q_job.arg[7:0];
            end
            OP_FIN_ERR: q_pop = slot_free;
            default:    q_pop = 1'b1;
          endcase
        end
      end
      ST_PAD: begin
        case (pad_stage)
          PS_MARK: begin
            absorb_en   = 1'b1;
            absorb_byte = PAD_MARK;
          end
          PS_ZERO: absorb_en = (fill != LEN_OFFSET);
          PS_LEN: begin
            absorb_en   = 1'b1;
            absorb_byte = len_sr[63:56];
          end
          default: absorb_en = 1'b0;
        endcase
      end
      default: q_pop = 1'b0;
    endcase
  end

  // one round of the compression
  always_comb begin
    if (rnd < 7'd20) begin
      f_val = (b & c) | (~b & d);
      k_val = K_R0;
    end else if (rnd < 7'd40) begin
      f_val = b ^ c ^ d;
      k_val = K_R1;
    end else if (rnd < 7'd60) begin
      f_val = (b & c) | (b & d) | (c & d);
      k_val = K_R2;
    end else begin
      f_val = b ^ c ^ d;
      k_val = K_R3;
    end
    t_next  = {a[26:0], a[31:27]} + f_val + e + w[0] + k_val;
    w_mix   = w[13] ^ w[8] ^ w[2] ^ w[0];
    w_sched = {w_mix[30:0], w_mix[31]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pad_stage <= PS_NONE;
      fill      <= '0;
      rnd       <= '0;
      len_cnt   <= '0;
      emit_idx  <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < 5; i++) chain[i] <= SHA1_IV[i];
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      if (absorb_en) begin
        wacc <= {wacc[15:0], absorb_byte};
        fill <= fill + 1'b1;
        if (fill[1:0] == 2'b11) begin
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= {wacc, absorb_byte};
        end
        // block is full: start compression
        if (fill == 6'd63) begin
          a     <= chain[0];
          b     <= chain[1];
          c     <= chain[2];
          d     <= chain[3];
          e     <= chain[4];
          rnd   <= '0;
          state <= ST_ROUND;
        end
      end

      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            case (q_job.op)
              OP_FIN_PAD: begin
                len_sr    <= q_job.arg;
                len_cnt   <= '0;
                pad_stage <= PS_MARK;
                state     <= ST_PAD;
              end
              OP_FIN_REPEAT: begin
                emit_idx <= '0;
                state    <= ST_EMIT;
              end
              OP_FIN_ERR: begin
                res_word.digest_word <= '0;
                res_word.word_index  <= '0;
                res_word.last_word   <= 1'b1;
                res_word.status      <= 1'b1;
              end
              OP_RESTART: begin
                for (int i = 0; i < 5; i++) chain[i] <= SHA1_IV[i];
                fill      <= '0;
                pad_stage <= PS_NONE;
              end
              default: begin
                pad_stage <= pad_stage;
              end
            endcase
          end
        end
        ST_PAD: begin
          case (pad_stage)
            PS_MARK: pad_stage <= PS_ZERO;
            PS_ZERO: begin
              if (fill == LEN_OFFSET) pad_stage <= PS_LEN;
            end
            PS_LEN: begin
              len_sr  <= {len_sr[55:0], 8'd0};
              len_cnt <= len_cnt + 1'b1;
              if (len_cnt == 3'd7) pad_stage <= PS_DONE;
            end
            default: pad_stage <= pad_stage;
          endcase
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= w_sched;
          a     <= t_next;
          b     <= a;
          c     <= {b[1:0], b[31:2]};
          d     <= c;
          e     <= d;
          rnd   <= rnd + 1'b1;
          if (rnd == LAST_ROUND) state <= ST_ADD;
        end
        ST_ADD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          chain[4] <= chain[4] + e;
          case (pad_stage)
            PS_NONE: state <= ST_IDLE;
            PS_DONE: begin
              emit_idx <= '0;
              state    <= ST_EMIT;
            end
            default: state <= ST_PAD;
          endcase
        end
        ST_EMIT: begin
          if (slot_free) begin
            res_word.digest_word <= chain[emit_idx];
            res_word.word_index  <= emit_idx;
            res_word.last_word   <= (emit_idx == LAST_DIGEST);
            res_word.status      <= 1'b0;
            emit_idx             <= emit_idx + 1'b1;
            if (emit_idx == LAST_DIGEST) begin
              pad_stage <= PS_NONE;
              state     <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (rnd <= LAST_ROUND))
    else $error("round counter past last round");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (emit_idx <= LAST_DIGEST))
    else $error("digest index out of range");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ST_IDLE && q_valid))
    else $error("job taken while core busy");

  a_pad_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD && pad_stage == PS_DONE) |=> (state == ST_EMIT))
    else $error("final block did not lead to digest output");

  a_error_word: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.status) |-> (res_word.last_word && res_word.word_index == 3'd0))
    else $error("error word is not a single last word");

endmodule
`default_nettype wire

/* src/sha1_byte_stream_hasher.sv */
// top level of the sha-1 byte stream hasher
// a word passes front end and queue and waits there until the core is idle
// absorb: one byte per job; a full block then adds 80 rounds and an add step
// sustained rate is set by the single round unit, which holds off new bytes
// finish: marker, zero and length bytes, one or two compressions, then 5 words
// rst is synchronous: clears queue, length, flags and loads the initial hash
`timescale 1ns / 1ps
`default_nettype none
module sha1_byte_stream_hasher
  import sha1h_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_stall,
  input  wire cmd_word_t cmd_word,
  output logic           res_valid,
  input  wire logic      res_stall,
  output res_word_t      res_word
);

  logic push;
  job_t push_job;
  logic q_full;
  logic q_pop;
  logic q_valid;
  job_t q_job;

  sha1h_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  sha1h_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_job)
  );

  sha1h_core u_core (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

endmodule
`default_nettype wire

/* tb/tb_sha1_byte_stream_hasher.sv */
// self-checking testbench of the sha-1 byte stream hasher with random input gaps and random result stalls
`timescale 1ns / 1ps
module tb_sha1_byte_stream_hasher;
  import sha1h_pkg::*;

  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam logic       STATUS_OK      = 1'b0;
  localparam logic       STATUS_CORRUPT = 1'b1;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         DRAIN_CYCLES   = 300;
  localparam int         RANDOM_ITEMS   = 24;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_word_t cmd_word = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_word_t res_word;

  sha1_byte_stream_hasher dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

  always #5 clk = ~clk;

  // running hash state of the message in flight
  logic [7:0]  msg_block [64];
  logic [6:0]  block_bytes;
  logic [31:0] chain [5];
  logic [63:0] msg_bits;
  bit          msg_done;
  bit          msg_bad;

  res_word_t digest_q [$];
  int        fails = 0;
  bit        send_quiet = 1'b0;
  int        hold_req = 0;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void compress_msg_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, tmp;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K_R0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K_R1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_R2;
      end else begin
        f = b ^ c ^ d;
        k = K_R3;
      end
      tmp = rol32(a, 5) + f + e + w[i] + k;
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = tmp;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
    block_bytes = '0;
  endfunction

  function automatic void clear_hash_state();
    foreach (msg_block[i]) msg_block[i] = '0;
    foreach (chain[i]) chain[i] = SHA1_IV[i];
    block_bytes = '0;
    msg_bits    = '0;
    msg_done    = 1'b0;
    msg_bad     = 1'b0;
  endfunction

  // marker byte, zeros, then the big-endian bit count; spills into a second block past 55 bytes
  function automatic void pad_message();
    int pos;
    pos = block_bytes[5:0];
    msg_block[pos] = PAD_MARK;
    pos++;
    if (pos > LEN_OFFSET) begin
      while (pos < 64) begin
        msg_block[pos] = '0;
        pos++;
      end
      compress_msg_block();
      pos = 0;
    end
    while (pos < LEN_OFFSET) begin
      msg_block[pos] = '0;
      pos++;
    end
    for (int i = 0; i < 8; i++)
      msg_block[LEN_OFFSET + i] = msg_bits[63 - 8*i -: 8];
    compress_msg_block();
  endfunction

  function automatic void hash_command(input cmd_word_t cw);
    res_word_t r;
    case (cw.mode)
      MODE_ABSORB: begin
        if (msg_done || msg_bad) begin
          msg_bad = 1'b1;
        end else begin
          msg_block[block_bytes[5:0]] = cw.data_byte;
          block_bytes = block_bytes + 7'd1;
          msg_bits    = msg_bits + 64'd8;
          if (msg_bits == '0) msg_bad = 1'b1;
          if (block_bytes >= 7'd64) compress_msg_block();
        end
      end
      MODE_FINISH: begin
        if (msg_bad) begin
          r.digest_word = '0;
          r.word_index  = '0;
          r.last_word   = 1'b1;
          r.status      = STATUS_CORRUPT;
          digest_q.push_back(r);
        end else begin
          if (!msg_done) begin
            pad_message();
            msg_done = 1'b1;
          end
          for (int i = 0; i <= LAST_DIGEST; i++) begin
            r.digest_word = chain[i];
            r.word_index  = 3'(i);
            r.last_word   = (i == LAST_DIGEST);
            r.status      = STATUS_OK;
            digest_q.push_back(r);
          end
        end
      end
      MODE_RESTART: clear_hash_state();
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_cmd(input logic [1:0] op_mode, input logic [7:0] data);
    int gap;
    gap = send_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word  <= '{mode: op_mode, data_byte: data};
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    hash_command(cmd_word);
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_cmd(MODE_ABSORB, 8'($urandom_range(0, 255)));
    send_cmd(MODE_FINISH, 8'($urandom_range(0, 255)));
    send_cmd(MODE_RESTART, 8'($urandom_range(0, 255)));
  endtask

  // receiver stalls: free runs and stall bursts, plus a long hold on request
  int hold_left = 0;
  int stall_left = 0;
  int free_left = 0;

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      res_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else begin
      free_left  = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(0, 6);
      stall_left = pick_gap();
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    res_word_t want;
    if (!rst && res_valid && !res_stall) begin
      if (digest_q.size() == 0) begin
        $error("unexpected result word %h", res_word);
        fails++;
      end else begin
        want = digest_q.pop_front();
        if (res_word.digest_word !== want.digest_word) begin
          $error("digest_word: expected %h, actual %h", want.digest_word, res_word.digest_word);
          fails++;
        end
        if (res_word.word_index !== want.word_index) begin
          $error("word_index: expected %0d, actual %0d", want.word_index, res_word.word_index);
          fails++;
        end
        if (res_word.last_word !== want.last_word) begin
          $error("last_word: expected %b, actual %b", want.last_word, res_word.last_word);
          fails++;
        end
        if (res_word.status !== want.status) begin
          $error("status: expected %b, actual %b", want.status, res_word.status);
          fails++;
        end
      end
    end
  end

  task automatic test_known_cases();
    send_cmd(MODE_FINISH, 8'h00);       // empty message
    send_cmd(MODE_RESTART, 8'hFF);
    send_cmd(MODE_ABSORB, 8'h61);
    send_cmd(MODE_ABSORB, 8'h62);
    send_cmd(MODE_ABSORB, 8'h63);
    send_cmd(MODE_FINISH, 8'hFF);
    send_cmd(MODE_FINISH, 8'h00);       // repeat gives the same digest
    send_cmd(MODE_ABSORB, 8'hFF);       // byte after finish corrupts the stream
    send_cmd(MODE_FINISH, 8'h5A);
    send_cmd(MODE_ABSORB, 8'h01);       // byte while corrupted is dropped
    send_cmd(MODE_UNUSED, 8'hAA);
    send_cmd(MODE_FINISH, 8'hA5);
    send_cmd(MODE_RESTART, 8'h00);
    send_cmd(MODE_ABSORB, 8'h00);
    send_cmd(MODE_UNUSED, 8'h55);       // ignored in the middle of a message
    send_cmd(MODE_ABSORB, 8'h80);
    send_cmd(MODE_FINISH, 8'h00);
    send_cmd(MODE_RESTART, 8'h00);
    wait_drained();
  endtask

  // 55 bytes pad in one block, 56 need two
  task automatic test_pad_boundaries();
    send_message(55);
    send_message(56);
    wait_drained();
  endtask

  task automatic test_result_backpressure();
    hold_req   = HOLD_CYCLES;
    send_quiet = 1'b1;
    repeat (4) send_message($urandom_range(1, 6));
    send_quiet = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_streams();
    int  sent;
    int  len;
    bit  paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      send_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(0, 9);
      end else begin
        case ($urandom_range(0, 4))
          0: len = 55;
          1: len = 56;
          2: len = 63;
          3: len = 64;
          default: len = 65;
        endcase
      end
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 29) == 0) send_cmd(MODE_UNUSED, 8'($urandom_range(0, 255)));
        send_cmd(MODE_ABSORB, 8'($urandom_range(0, 255)));
        sent++;
      end
      // abandoned message
      if ($urandom_range(0, 19) == 0) begin
        send_cmd(MODE_RESTART, 8'($urandom_range(0, 255)));
        sent++;
        continue;
      end
      send_cmd(MODE_FINISH, 8'($urandom_range(0, 255)));
      sent++;
      if ($urandom_range(0, 4) == 0) begin
        send_cmd(MODE_FINISH, 8'($urandom_range(0, 255)));
        sent++;
      end
      // stray bytes after finish, then the error word
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_cmd(MODE_ABSORB, 8'($urandom_range(0, 255)));
          sent++;
        end
        send_cmd(MODE_FINISH, 8'($urandom_range(0, 255)));
        sent++;
      end
      send_cmd(MODE_RESTART, 8'($urandom_range(0, 255)));
      sent++;
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    send_quiet = 1'b0;
    wait_drained();
  endtask

  initial begin
    clear_hash_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_known_cases();
    test_pad_boundaries();
    test_result_backpressure();
    test_random_streams();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && digest_q.size() == 0) begin
      $display("[sha1_byte_stream_hasher] OK");
    end else begin
      $display("[sha1_byte_stream_hasher] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[sha1_byte_stream_hasher] ERROR");
    $finish;
  end

endmodule
